// ===== hw/rtl/quadrature_dimmer_control_assert.svh =====
// Assertion macros for the RTL file of the quadrature dimmer control.
`ifndef QUADRATURE_DIMMER_CONTROL_ASSERT_SVH
`define QUADRATURE_DIMMER_CONTROL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QDC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define QDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/qdc_pkg.sv =====
`timescale 1ns / 1ps

package qdc_pkg;

    localparam int MAX_LEVEL_DEF = 10;
    localparam int LEVEL_W       = 4;
    localparam int DUTY_W        = 8;
    localparam int DUTY_FULL     = 255;

    typedef logic [1:0] phase_t;

    localparam phase_t PHASE_00 = 2'b00;
    localparam phase_t PHASE_01 = 2'b01;
    localparam phase_t PHASE_11 = 2'b11;
    localparam phase_t PHASE_10 = 2'b10;

    typedef struct packed {
        logic phase_a;
        logic phase_b;
        logic button_level;
    } qdc_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level_one;
        logic [LEVEL_W-1:0] level_two;
        logic [DUTY_W-1:0]  duty_one;
        logic [DUTY_W-1:0]  duty_two;
        logic               selected_channel;
    } qdc_out_t;

    // Next phase pair in the forward Gray sequence.
    function automatic phase_t phase_fwd(input phase_t p);
        phase_t n;
        unique case (p)
            PHASE_00: n = PHASE_01;
            PHASE_01: n = PHASE_11;
            PHASE_11: n = PHASE_10;
            PHASE_10: n = PHASE_00;
            default:  n = PHASE_00;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/quadrature_dimmer_control.sv =====
`timescale 1ns / 1ps

// Quadrature dimmer control. Each request is one sample of the encoder phase
// pins and the push button; every request yields one result with both channel
// levels, their PWM duties and the selected channel. A new request is taken in
// every cycle unless the input register is full and the waiting result is not
// taken. Its result is offered once the input register hands it to the result
// register. The duty of each channel is tracked alongside its level as a
// quotient and remainder, so a level step needs no multiply or divide. The
// direction register resets to reversed.
`include "quadrature_dimmer_control_assert.svh"

module quadrature_dimmer_control
    import qdc_pkg::*;
#(
    parameter int MAX_LEVEL = MAX_LEVEL_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  qdc_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output qdc_out_t out_data,
    input  logic     cfg_write,
    input  logic     cfg_data
);

    localparam int LW        = $clog2(MAX_LEVEL + 1);
    localparam int RW        = (MAX_LEVEL > 1) ? $clog2(MAX_LEVEL) : 1;
    localparam int DUTY_STEP = DUTY_FULL / MAX_LEVEL;
    localparam int DUTY_REM  = DUTY_FULL % MAX_LEVEL;

    logic              reverse_reg;
    logic              s1_valid_reg, s1_valid_next;
    qdc_in_t           in_reg;
    logic              out_valid_reg, out_valid_next;
    qdc_out_t          out_reg, out_next;
    phase_t            prev_phase_reg, prev_phase_next;
    logic              captured_reg, captured_next;
    logic              prev_button_reg, prev_button_next;
    logic              sel_reg, sel_next;
    logic [LW-1:0]     level_reg [2];
    logic [LW-1:0]     level_next [2];
    logic [DUTY_W-1:0] duty_reg [2];
    logic [DUTY_W-1:0] duty_next [2];
    logic [RW-1:0]     rem_reg [2];
    logic [RW-1:0]     rem_next [2];

    logic              in_fire;
    logic              s1_adv;
    logic              proc;
    phase_t            cur_phase;
    logic              fwd_move, bwd_move, step_up, step_dn;
    logic [LW-1:0]     sel_level;
    logic [DUTY_W-1:0] sel_duty;
    logic [RW-1:0]     sel_rem;
    logic [RW:0]       rem_sum;
    logic              rem_wrap;
    logic              rem_borrow;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;
    assign proc     = s1_valid_reg && s1_adv;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign cur_phase = {in_reg.phase_a, in_reg.phase_b};
    assign fwd_move  = (phase_fwd(prev_phase_reg) == cur_phase);
    assign bwd_move  = (phase_fwd(cur_phase) == prev_phase_reg);
    assign step_up   = reverse_reg ? bwd_move : fwd_move;
    assign step_dn   = reverse_reg ? fwd_move : bwd_move;

    assign sel_level  = level_reg[sel_reg];
    assign sel_duty   = duty_reg[sel_reg];
    assign sel_rem    = rem_reg[sel_reg];
    assign rem_sum    = {1'b0, sel_rem} + (RW+1)'(DUTY_REM);
    assign rem_wrap   = (rem_sum >= (RW+1)'(MAX_LEVEL));
    assign rem_borrow = ({1'b0, sel_rem} < (RW+1)'(DUTY_REM));

    always_comb
    begin
        s1_valid_next    = s1_valid_reg;
        out_valid_next   = out_valid_reg;
        prev_phase_next  = prev_phase_reg;
        captured_next    = captured_reg;
        prev_button_next = prev_button_reg;
        sel_next         = sel_reg;
        level_next       = level_reg;
        duty_next        = duty_reg;
        rem_next         = rem_reg;

        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        if (s1_adv)
        begin
            out_valid_next = s1_valid_reg;
        end

        if (proc)
        begin
            if (!captured_reg)
            begin
                captured_next = 1'b1;
            end
            else if (step_up && (sel_level < LW'(MAX_LEVEL)))
            begin
                level_next[sel_reg] = sel_level + LW'(1);
                rem_next[sel_reg]   = rem_wrap ? RW'(rem_sum - (RW+1)'(MAX_LEVEL))
                                               : RW'(rem_sum);
                duty_next[sel_reg]  = sel_duty + DUTY_W'(DUTY_STEP) + DUTY_W'(rem_wrap);
            end
            else if (step_dn && (sel_level != '0))
            begin
                level_next[sel_reg] = sel_level - LW'(1);
                rem_next[sel_reg]   = rem_borrow
                    ? RW'({1'b0, sel_rem} + (RW+1)'(MAX_LEVEL) - (RW+1)'(DUTY_REM))
                    : RW'({1'b0, sel_rem} - (RW+1)'(DUTY_REM));
                duty_next[sel_reg]  = sel_duty - DUTY_W'(DUTY_STEP) - DUTY_W'(rem_borrow);
            end

            prev_phase_next = cur_phase;

            if (!prev_button_reg && in_reg.button_level)
            begin
                sel_next = !sel_reg;
            end
            prev_button_next = in_reg.button_level;
        end

        out_next                  = out_reg;
        out_next.level_one        = LEVEL_W'(level_next[0]);
        out_next.level_two        = LEVEL_W'(level_next[1]);
        out_next.duty_one         = duty_next[0];
        out_next.duty_two         = duty_next[1];
        out_next.selected_channel = sel_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg     <= 1'b1;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prev_phase_reg  <= PHASE_00;
            captured_reg    <= 1'b0;
            prev_button_reg <= 1'b1;
            sel_reg         <= 1'b0;
            level_reg[0]    <= '0;
            level_reg[1]    <= '0;
            duty_reg[0]     <= '0;
            duty_reg[1]     <= '0;
            rem_reg[0]      <= '0;
            rem_reg[1]      <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                reverse_reg <= cfg_data;
            end
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            prev_phase_reg  <= prev_phase_next;
            captured_reg    <= captured_next;
            prev_button_reg <= prev_button_next;
            sel_reg         <= sel_next;
            level_reg       <= level_next;
            duty_reg        <= duty_next;
            rem_reg         <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_reg <= in_data;
        end
        if (proc)
        begin
            out_reg <= out_next;
        end
    end

    `QDC_ASSERT_SAME(a_full_level_full_duty, level_reg[0] == LW'(MAX_LEVEL),
        duty_reg[0] == DUTY_W'(DUTY_FULL) && rem_reg[0] == '0)
    `QDC_ASSERT_SAME(a_zero_level_zero_duty, level_reg[1] == '0,
        duty_reg[1] == '0 && rem_reg[1] == '0)
    `QDC_ASSERT_SAME(a_stall_only_when_full, !in_ready,
        s1_valid_reg && out_valid_reg && !out_ready)
    `QDC_ASSERT_NEXT(a_release_toggles, proc && !prev_button_reg && in_reg.button_level,
        sel_reg != $past(sel_reg))
    `QDC_ASSERT_NEXT(a_held_request_stays, s1_valid_reg && !s1_adv,
        s1_valid_reg && $stable(in_reg))

endmodule

// ===== test/tb_quadrature_dimmer_control.sv =====
`timescale 1ns / 1ps

module tb_quadrature_dimmer_control;
    import qdc_pkg::*;

    localparam int DIM_MAX      = MAX_LEVEL_DEF;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 175;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_MAX   = 10;

    typedef struct packed {
        qdc_in_t  sample;
        logic     known;
        qdc_out_t want;
    } sample_row_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    qdc_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    qdc_out_t out_data;
    logic     cfg_write = 1'b0;
    logic     cfg_data  = 1'b0;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    sample_row_t typed_q[$];
    qdc_out_t    dimmer_due[$];

    bit     dir_reversed = 1'b1;
    phase_t last_phase   = PHASE_00;
    bit     phase_seen   = 1'b0;
    bit     last_button  = 1'b1;
    bit     sel          = 1'b0;
    int     lvl [2]      = '{0, 0};

    phase_t fwd_of [4] = '{PHASE_01, PHASE_11, PHASE_00, PHASE_10};
    phase_t bwd_of [4] = '{PHASE_10, PHASE_00, PHASE_11, PHASE_01};

    phase_t walk_phase  = PHASE_00;
    bit     walk_up     = 1'b1;
    int     run_left    = 0;
    bit     walk_button = 1'b1;

    sample_row_t directed [20] = '{
        '{3'b011, 1'b1, '0},
        '{3'b111, 1'b1, '0},
        '{3'b101, 1'b1, '0},
        '{3'b001, 1'b1, '0},
        '{3'b101, 1'b0, '0},
        '{3'b111, 1'b0, '0},
        '{3'b011, 1'b0, '0},
        '{3'b001, 1'b0, '0},
        '{3'b111, 1'b0, '0},
        '{3'b111, 1'b0, '0},
        '{3'b001, 1'b0, '0},
        '{3'b011, 1'b0, '0},
        '{3'b010, 1'b0, '0},
        '{3'b011, 1'b0, '0},
        '{3'b001, 1'b0, '0},
        '{3'b100, 1'b0, '0},
        '{3'b111, 1'b0, '0},
        '{3'b110, 1'b0, '0},
        '{3'b100, 1'b0, '0},
        '{3'b101, 1'b0, '0}
    };

    quadrature_dimmer_control uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic qdc_out_t dimmer_step(input qdc_in_t s);
        phase_t   now;
        int       move;
        qdc_out_t r;
        now = {s.phase_a, s.phase_b};
        if (!phase_seen)
            phase_seen = 1'b1;
        else
        begin
            move = 0;
            if (fwd_of[last_phase] == now)
                move = 1;
            else if (bwd_of[last_phase] == now)
                move = -1;
            if (dir_reversed)
                move = -move;
            if (move > 0 && lvl[sel] < DIM_MAX)
                lvl[sel] = lvl[sel] + 1;
            else if (move < 0 && lvl[sel] > 0)
                lvl[sel] = lvl[sel] - 1;
        end
        last_phase = now;
        if (!last_button && s.button_level)
            sel = ~sel;
        last_button = s.button_level;
        r.level_one        = LEVEL_W'(lvl[0]);
        r.level_two        = LEVEL_W'(lvl[1]);
        r.duty_one         = DUTY_W'((lvl[0] * DUTY_FULL) / DIM_MAX);
        r.duty_two         = DUTY_W'((lvl[1] * DUTY_FULL) / DIM_MAX);
        r.selected_channel = sel;
        return r;
    endfunction

    // Requests mostly follow a Gray-code walk in runs of one direction, so the
    // levels reach both bounds; the rest hold still, reverse or jump two bits.
    function automatic sample_row_t random_row();
        sample_row_t row;
        int          r;
        if (run_left == 0)
        begin
            walk_up  = ($urandom_range(1) != 0);
            run_left = $urandom_range(30, 3);
        end
        run_left = run_left - 1;
        r = $urandom_range(99);
        if (r < 70)
            walk_phase = walk_up ? fwd_of[walk_phase] : bwd_of[walk_phase];
        else if (r < 78)
            walk_phase = walk_up ? bwd_of[walk_phase] : fwd_of[walk_phase];
        else if (r >= 88)
            walk_phase = ~walk_phase;
        if ($urandom_range(99) < 12)
            walk_button = ~walk_button;
        row.sample = {walk_phase, walk_button};
        row.known  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    task automatic send_row(input sample_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        typed_q.push_back(row);
        in_valid <= 1'b1;
        in_data  <= row.sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (dimmer_due.size() != 0 || typed_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_register(input bit reversed);
        cfg_write <= 1'b1;
        cfg_data  <= reversed;
        @(posedge clk);
        cfg_write <= 1'b0;
        dir_reversed = reversed;
    endtask

    task automatic compare_result(input qdc_out_t want, input qdc_out_t got);
        if (got.level_one !== want.level_one || got.level_two !== want.level_two
            || got.duty_one !== want.duty_one || got.duty_two !== want.duty_two
            || got.selected_channel !== want.selected_channel)
        begin
            mismatches = mismatches + 1;
            if (mismatches <= REPORT_MAX)
                $display("%0t: result mismatch, expected lvl %0d/%0d duty %0d/%0d sel %0b,",
                         $time, want.level_one, want.level_two, want.duty_one,
                         want.duty_two, want.selected_channel,
                         " got lvl %0d/%0d duty %0d/%0d sel %0b",
                         got.level_one, got.level_two, got.duty_one, got.duty_two,
                         got.selected_channel);
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        sample_row_t row;
        qdc_out_t    model;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                row   = typed_q.pop_front();
                model = dimmer_step(in_data);
                dimmer_due.push_back(row.known ? row.want : model);
            end
            if (out_valid && out_ready)
            begin
                if (dimmer_due.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: result with no request pending", $time);
                end
                else
                    compare_result(dimmer_due.pop_front(), out_data);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_row(directed[i]);
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_register(p % 2 != 0);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 83;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 83;
                end
                default:
                begin
                    send_idle_pct = 36;
                    stall_pct     = 36;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    settle();
                send_row(random_row());
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (dimmer_due.size() != 0)
        begin
            mismatches = mismatches + 1;
            $display("%0d results never arrived", dimmer_due.size());
        end
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
